FILE: sv/assert_macros.svh
// Assertion shorthands used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, off during reset
`define ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// next-cycle implication, always live
`define ASSERT_AFTER(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: sv/spdp_pkg.sv
package spdp_pkg;

   typedef logic [63:0] word_type;

   // register stages through one fused multiply-add
   localparam int FMA_LAT = 10;

   localparam int EXP_W = 14;
   typedef logic signed [EXP_W-1:0] exp_type;

   localparam word_type NEG_ONE   = 64'hBFF0_0000_0000_0000;
   localparam word_type NEG_ZERO  = 64'h8000_0000_0000_0000;
   localparam word_type ONE_BITS  = 64'h3FF0_0000_0000_0000;
   localparam word_type QUIET_BIT = 64'h0008_0000_0000_0000;
   localparam word_type POS_DNAN  = 64'h7FF8_0000_0000_0000;

   localparam word_type COEF [10] = '{
      64'h400921FB54442D18, 64'hC014ABBCE625BE53,
      64'h400466BC6775AB16, 64'hBFE32D2CCE62DC33,
      64'h3FB507834891188E, 64'hBF7E30750A28C88E,
      64'h3F3E8F48308ACDA4, 64'hBEF6FC0032B3C29F,
      64'h3EAAF86AE521260B, 64'hBE6012A9870EEB7D
   };

   // leading zero count, 128 for an all-zero word
   function automatic logic [7:0] lzc128(input logic [127:0] x);
      logic [127:0] v;
      logic [7:0]   n;
      v = x;
      n = 8'd0;
      if (x == 128'd0) begin
         n = 8'd128;
      end else begin
         if (v[127:64] == 64'd0) begin n[6] = 1'b1; v = v << 64; end
         if (v[127:96] == 32'd0) begin n[5] = 1'b1; v = v << 32; end
         if (v[127:112] == 16'd0) begin n[4] = 1'b1; v = v << 16; end
         if (v[127:120] == 8'd0) begin n[3] = 1'b1; v = v << 8; end
         if (v[127:124] == 4'd0) begin n[2] = 1'b1; v = v << 4; end
         if (v[127:126] == 2'd0) begin n[1] = 1'b1; v = v << 2; end
         if (v[127] == 1'b0) begin n[0] = 1'b1; end
      end
      return n;
   endfunction

endpackage

FILE: sv/sinpi_double_polynomial_core.sv
// channel  direction  ports                              word
// req      in         req_valid, req_stall, req_arg_bits x, binary64
// rsp      out        rsp_valid, rsp_stall, rsp_result_bits sin(pi*x), binary64
//
// One word in and one word out per cycle while rsp is not stalled.
// A result passes through the input register, the reduction register,
// eight chained multiply-add units of 10 stages each and the output
// register.
// Reset is synchronous and clears the valid bits only.
// A stall on rsp with a word waiting freezes the whole pipeline and raises
// req_stall in the same cycle.
module sinpi_double_polynomial_core import spdp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_arg_bits,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_result_bits
);

   localparam int SIDE_D = 8 * FMA_LAT;
   localparam int RED_D  = 6 * FMA_LAT;
   localparam int QD_D   = 3 * FMA_LAT;

   function automatic word_type round_away(input word_type v);
      logic [10:0] fld;
      logic [5:0]  k;
      word_type    t;
      fld = v[62:52];
      k   = 6'(11'd1075 - fld);
      t   = v + (64'd1 << (k - 6'd1));
      if (fld >= 11'd1075) begin
         return v;
      end else if (fld < 11'd1022) begin
         return {v[63], 63'd0};
      end else if (fld == 11'd1022) begin
         return {v[63], 63'd0} | ONE_BITS;
      end
      return t & ~((64'd1 << k) - 64'd1);
   endfunction

   // parity of the saturating int64 conversion
   function automatic logic low_int_bit(input word_type v);
      logic [10:0] fld;
      word_type    sig;
      fld = v[62:52];
      sig = {11'd0, 1'b1, v[51:0]} >> (11'd1075 - fld);
      if (fld >= 11'd1086) begin
         return !v[63];
      end else if ((fld > 11'd1075) || (fld < 11'd1023)) begin
         return 1'b0;
      end
      return sig[0];
   endfunction

   logic     en;
   logic     v0_ff, v1_ff, rsp_valid_ff;
   word_type arg0_ff, arg1_ff, nint1_ff, sval1_ff, rsp_data_ff;
   logic     spec1_ff;
   word_type sval_w;

   logic     side_v_ff    [SIDE_D];
   logic     side_flip_ff [SIDE_D];
   logic     side_spec_ff [SIDE_D];
   word_type side_sval_ff [SIDE_D];
   word_type red_dly_ff   [RED_D];
   word_type qd_dly_ff    [QD_D];
   word_type p2_dly_ff    [FMA_LAT];
   word_type p1_dly_ff    [2*FMA_LAT];
   word_type p0_dly_ff    [QD_D];

   word_type red_w, sq_w, qd_w, res_w;
   word_type pair_w [5];
   word_type acc_w  [4];
   word_type qd_tap [4];
   word_type pair_tap [4];

   assign en        = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !en;

   // NaN keeps its payload, quietened; infinities give the default NaN with the sign flipped
   assign sval_w = (arg0_ff[51:0] != 52'd0) ? (arg0_ff | QUIET_BIT)
                 : (arg0_ff[63] ? POS_DNAN : (POS_DNAN | NEG_ZERO));

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff        <= 1'b0;
         v1_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < SIDE_D; i++) begin
            side_v_ff[i] <= 1'b0;
         end
      end else if (en) begin
         v0_ff        <= req_valid;
         v1_ff        <= v0_ff;
         rsp_valid_ff <= side_v_ff[SIDE_D-1];
         side_v_ff[0] <= v1_ff;
         for (int i = 1; i < SIDE_D; i++) begin
            side_v_ff[i] <= side_v_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         arg0_ff  <= req_arg_bits;
         arg1_ff  <= arg0_ff;
         nint1_ff <= round_away(arg0_ff);
         spec1_ff <= (arg0_ff[62:52] == 11'h7FF);
         sval1_ff <= sval_w;

         side_flip_ff[0] <= low_int_bit(nint1_ff);
         side_spec_ff[0] <= spec1_ff;
         side_sval_ff[0] <= sval1_ff;
         for (int i = 1; i < SIDE_D; i++) begin
            side_flip_ff[i] <= side_flip_ff[i-1];
            side_spec_ff[i] <= side_spec_ff[i-1];
            side_sval_ff[i] <= side_sval_ff[i-1];
         end

         red_dly_ff[0] <= red_w;
         for (int i = 1; i < RED_D; i++) begin
            red_dly_ff[i] <= red_dly_ff[i-1];
         end

         qd_dly_ff[0] <= qd_w;
         p0_dly_ff[0] <= pair_w[0];
         for (int i = 1; i < QD_D; i++) begin
            qd_dly_ff[i] <= qd_dly_ff[i-1];
            p0_dly_ff[i] <= p0_dly_ff[i-1];
         end
         p1_dly_ff[0] <= pair_w[1];
         for (int i = 1; i < 2*FMA_LAT; i++) begin
            p1_dly_ff[i] <= p1_dly_ff[i-1];
         end
         p2_dly_ff[0] <= pair_w[2];
         for (int i = 1; i < FMA_LAT; i++) begin
            p2_dly_ff[i] <= p2_dly_ff[i-1];
         end

         if (side_spec_ff[SIDE_D-1]) begin
            rsp_data_ff <= side_sval_ff[SIDE_D-1];
         end else begin
            rsp_data_ff <= res_w ^ {side_flip_ff[SIDE_D-1], 63'd0};
         end
      end
   end

   assign qd_tap[0]   = qd_w;
   assign qd_tap[1]   = qd_dly_ff[FMA_LAT-1];
   assign qd_tap[2]   = qd_dly_ff[2*FMA_LAT-1];
   assign qd_tap[3]   = qd_dly_ff[3*FMA_LAT-1];
   assign pair_tap[3] = pair_w[3];
   assign pair_tap[2] = p2_dly_ff[FMA_LAT-1];
   assign pair_tap[1] = p1_dly_ff[2*FMA_LAT-1];
   assign pair_tap[0] = p0_dly_ff[3*FMA_LAT-1];

   // r = x - n
   spdp_fma u_red (
      .clock(clock), .en(en), .op_a(nint1_ff), .op_b(NEG_ONE), .op_c(arg1_ff), .result(red_w)
   );

   spdp_fma u_sq (
      .clock(clock), .en(en), .op_a(red_w), .op_b(red_w), .op_c(NEG_ZERO), .result(sq_w)
   );

   spdp_fma u_qd (
      .clock(clock), .en(en), .op_a(sq_w), .op_b(sq_w), .op_c(NEG_ZERO), .result(qd_w)
   );

   for (genvar k = 0; k < 5; k++) begin : g_pair
      spdp_fma u_pair (
         .clock(clock), .en(en), .op_a(sq_w), .op_b(COEF[2*k+1]), .op_c(COEF[2*k]),
         .result(pair_w[k])
      );
   end

   // Horner in r^4, highest pair first
   for (genvar j = 0; j < 4; j++) begin : g_horner
      spdp_fma u_step (
         .clock(clock), .en(en), .op_a(qd_tap[j]),
         .op_b((j == 0) ? pair_w[4] : acc_w[(j == 0) ? 0 : j-1]),
         .op_c(pair_tap[3-j]), .result(acc_w[j])
      );
   end

   spdp_fma u_res (
      .clock(clock), .en(en), .op_a(acc_w[3]), .op_b(red_dly_ff[RED_D-1]), .op_c(NEG_ZERO),
      .result(res_w)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_bits = rsp_data_ff;

endmodule

FILE: sv/spdp_fma.sv
module spdp_fma import spdp_pkg::*; (
   input  logic     clock,
   input  logic     en,
   input  word_type op_a,
   input  word_type op_b,
   input  word_type op_c,
   output word_type result
);

   // a*b + c, finite operands, one rounding to nearest even
   typedef struct packed {
      logic     ovr;
      word_type ovrv;
   } side_type;

   function automatic exp_type unpack_exp(input logic [10:0] fld);
      return exp_type'({3'b000, (fld == 11'd0) ? 11'd1 : fld}) - exp_type'(1075);
   endfunction

   logic [10:0] fa, fb, fc;
   logic [52:0] ma, mb, mc;
   logic        sp_w;
   side_type    side_in;
   side_type    side_ff [9];

   assign fa = op_a[62:52];
   assign fb = op_b[62:52];
   assign fc = op_c[62:52];
   assign ma = {fa != 11'd0, op_a[51:0]};
   assign mb = {fb != 11'd0, op_b[51:0]};
   assign mc = {fc != 11'd0, op_c[51:0]};
   assign sp_w = op_a[63] ^ op_b[63];
   assign side_in.ovr = (ma == 53'd0) || (mb == 53'd0);
   assign side_in.ovrv = (mc != 53'd0) ? op_c : {op_c[63] & sp_w, 63'd0};

   // stage 1: unpack, partial products
   logic [53:0] pp00_ff;
   logic [52:0] pp01_ff, pp10_ff;
   logic [51:0] pp11_ff;
   exp_type     ep1_ff, ec1_ff;
   logic [52:0] mc1_ff;
   logic        sp1_ff, sc1_ff, az1_ff;

   // stage 2: product sum
   logic [105:0] pm2_ff;
   logic [5:0]   lza2_ff;
   exp_type      ep2_ff, ec2_ff;
   logic [52:0]  mc2_ff;
   logic         sp2_ff, sc2_ff, az2_ff;

   // stage 3
   logic [105:0] pm3_ff;
   logic [6:0]   lzp3_ff;
   logic [52:0]  am3_ff;
   exp_type      ep3_ff, ea3_ff;
   logic         sp3_ff, sc3_ff, az3_ff;

   // stage 4: both normalised, top bit at the msb
   logic [105:0] pm4_ff;
   logic [52:0]  am4_ff;
   exp_type      ep4_ff, ea4_ff;
   logic         sp4_ff, sc4_ff, az4_ff;

   // stage 5: ordered by magnitude
   logic [127:0] big5_ff, sml5_ff;
   logic [6:0]   d5_ff;
   exp_type      eb5_ff;
   logic         bs5_ff, sub5_ff;

   // stage 6: aligned
   logic [127:0] big6_ff, sml6_ff;
   exp_type      eb6_ff;
   logic         bs6_ff, sub6_ff;

   // stage 7: sum
   logic [127:0] res7_ff;
   exp_type      eb7_ff;
   logic         bs7_ff;

   // stage 8
   logic [127:0] res8_ff;
   logic [7:0]   lz8_ff;
   exp_type      er8_ff;
   logic         bs8_ff, z8_ff;

   // stage 9: rounded mantissa before increment
   logic [63:0]  m9_ff;
   logic         inc9_ff, bs9_ff, z9_ff;
   exp_type      q9_ff;

   word_type     result_ff;

   logic [105:0] am_w;
   logic         pbig;
   exp_type      dexp;
   logic [127:0] sml_sh;
   logic         sml_stk;
   logic [6:0]   top9;
   exp_type      qraw, qcl, shv;
   logic [7:0]   shc;
   logic [5:0]   lsh;
   logic [255:0] ext;
   logic [63:0]  mr, mn;
   exp_type      qn, be;
   word_type     packed_w;

   always_comb begin
      am_w = {am4_ff, 53'd0};
      pbig = az4_ff || (ep4_ff > ea4_ff) || ((ep4_ff == ea4_ff) && (pm4_ff >= am_w));
      dexp = pbig ? (ep4_ff - ea4_ff) : (ea4_ff - ep4_ff);

      sml_sh  = sml5_ff >> d5_ff;
      sml_stk = |(sml5_ff & ~({128{1'b1}} << d5_ff));

      top9 = 7'(8'd127 - lz8_ff);
      qraw = er8_ff + exp_type'({7'd0, top9}) - exp_type'(52);
      qcl  = (qraw < exp_type'(-1074)) ? exp_type'(-1074) : qraw;
      shv  = qcl - er8_ff;
      shc  = (shv > exp_type'(255)) ? 8'd255 : shv[7:0];
      lsh  = 6'(exp_type'(0) - shv);
      ext  = {res8_ff, 128'd0} >> shc;

      mr = m9_ff + {63'd0, inc9_ff};
      if (mr == 64'h0020_0000_0000_0000) begin
         mn = mr >> 1;
         qn = q9_ff + exp_type'(1);
      end else begin
         mn = mr;
         qn = q9_ff;
      end
      be = qn + exp_type'(1075);
      if (mn >= 64'h0010_0000_0000_0000) begin
         if (be >= exp_type'(2047)) begin
            packed_w = {bs9_ff, 11'h7FF, 52'd0};
         end else begin
            packed_w = {bs9_ff, be[10:0], mn[51:0]};
         end
      end else begin
         packed_w = {bs9_ff, mn[62:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pp00_ff <= {27'd0, ma[26:0]} * {27'd0, mb[26:0]};
         pp01_ff <= {26'd0, ma[26:0]} * {27'd0, mb[52:27]};
         pp10_ff <= {27'd0, ma[52:27]} * {26'd0, mb[26:0]};
         pp11_ff <= {26'd0, ma[52:27]} * {26'd0, mb[52:27]};
         ep1_ff  <= unpack_exp(fa) + unpack_exp(fb);
         ec1_ff  <= unpack_exp(fc);
         mc1_ff  <= mc;
         sp1_ff  <= sp_w;
         sc1_ff  <= op_c[63];
         az1_ff  <= (mc == 53'd0);

         pm2_ff  <= {52'd0, pp00_ff} + ({53'd0, pp01_ff} << 27)
                  + ({53'd0, pp10_ff} << 27) + ({54'd0, pp11_ff} << 54);
         lza2_ff <= 6'(lzc128({mc1_ff, 75'd0}));
         ep2_ff  <= ep1_ff;
         ec2_ff  <= ec1_ff;
         mc2_ff  <= mc1_ff;
         sp2_ff  <= sp1_ff;
         sc2_ff  <= sc1_ff;
         az2_ff  <= az1_ff;

         pm3_ff  <= pm2_ff;
         lzp3_ff <= 7'(lzc128({pm2_ff, 22'd0}));
         am3_ff  <= mc2_ff << lza2_ff;
         ea3_ff  <= ec2_ff - exp_type'({8'd0, lza2_ff}) - exp_type'(53);
         ep3_ff  <= ep2_ff;
         sp3_ff  <= sp2_ff;
         sc3_ff  <= sc2_ff;
         az3_ff  <= az2_ff;

         pm4_ff  <= pm3_ff << lzp3_ff;
         ep4_ff  <= ep3_ff - exp_type'({7'd0, lzp3_ff});
         am4_ff  <= am3_ff;
         ea4_ff  <= ea3_ff;
         sp4_ff  <= sp3_ff;
         sc4_ff  <= sc3_ff;
         az4_ff  <= az3_ff;

         // carry bit on top, guard bits below
         big5_ff <= {1'b0, pbig ? pm4_ff : am_w, 21'd0};
         sml5_ff <= {1'b0, pbig ? am_w : pm4_ff, 21'd0};
         d5_ff   <= (dexp > exp_type'(127)) ? 7'd127 : dexp[6:0];
         eb5_ff  <= pbig ? ep4_ff : ea4_ff;
         bs5_ff  <= pbig ? sp4_ff : sc4_ff;
         sub5_ff <= sp4_ff ^ sc4_ff;

         big6_ff <= big5_ff;
         sml6_ff <= sml_sh | {127'd0, sml_stk};
         eb6_ff  <= eb5_ff;
         bs6_ff  <= bs5_ff;
         sub6_ff <= sub5_ff;

         res7_ff <= sub6_ff ? (big6_ff - sml6_ff) : (big6_ff + sml6_ff);
         eb7_ff  <= eb6_ff;
         bs7_ff  <= bs6_ff;

         res8_ff <= res7_ff;
         lz8_ff  <= lzc128(res7_ff);
         z8_ff   <= (res7_ff == 128'd0);
         er8_ff  <= eb7_ff - exp_type'(21);
         bs8_ff  <= bs7_ff;

         m9_ff   <= (shv <= exp_type'(0)) ? (res8_ff[63:0] << lsh) : ext[191:128];
         inc9_ff <= (shv > exp_type'(0)) && ext[127] && ((|ext[126:0]) || ext[128]);
         q9_ff   <= qcl;
         bs9_ff  <= bs8_ff;
         z9_ff   <= z8_ff;

         // exact cancellation gives +0
         if (side_ff[8].ovr) begin
            result_ff <= side_ff[8].ovrv;
         end else if (z9_ff) begin
            result_ff <= 64'd0;
         end else begin
            result_ff <= packed_w;
         end

         side_ff[0] <= side_in;
         for (int i = 1; i < 9; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   assign result = result_ff;

endmodule

FILE: sv/spdp_checker.sv
`include "assert_macros.svh"

module spdp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [63:0] req_arg_bits,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [63:0] rsp_result_bits
);

   logic req_seen;
   assign req_seen = req_valid || (req_arg_bits != 64'd0) || 1'b1;

   // input held back only by a waiting result
   `ASSERT_IMP(a_stall_cause, clock, reset, req_seen && req_stall, rsp_valid && rsp_stall)

   `ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_result_bits))

   `ASSERT_AFTER(a_reset_empty, clock, reset, !rsp_valid && !req_stall)

endmodule

bind sinpi_double_polynomial_core spdp_checker u_chk (.*);
